### src/tfpc_pkg.sv
// Shared types and constants for the four-point touch calibrator.
// Holds status codes, register indexes, divider sizes and the controller/datapath
// command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package tfpc_pkg;

  localparam int RAW_BITS = 12;
  localparam int BND_W    = 23;
  localparam int COEF_W   = 24;
  localparam int DIV_NW   = 40;
  localparam int DIV_DW   = 24;
  localparam int DIV_CW   = 6;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_POINT   = 3'd1;
  localparam logic [2:0] ST_CAL_OK  = 3'd2;
  localparam logic [2:0] ST_CAL_ERR = 3'd3;
  localparam logic [2:0] ST_COEF    = 3'd4;
  localparam logic [2:0] ST_QUIT    = 3'd5;

  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_XOFF     = 2'd2;
  localparam logic [1:0] CFG_FULL     = 2'd3;

  localparam logic [12:0] SCREEN_W_RST = 13'd800;
  localparam logic [12:0] SCREEN_H_RST = 13'd600;
  localparam logic [7:0]  XOFF_RST     = 8'd20;
  localparam logic [11:0] FULL_RST     = 12'd4095;

  localparam logic [2:0] LAST_CORNER = 3'd3;

  typedef enum logic [2:0] {
    DS_AVGX = 3'd0,
    DS_AVGY = 3'd1,
    DS_TX   = 3'd2,
    DS_TY   = 3'd3,
    DS_GX   = 3'd4,
    DS_OX   = 3'd5,
    DS_GY   = 3'd6,
    DS_OY   = 3'd7
  } div_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     edge_step;
    logic     sum_step;
    logic     div_start;
    logic     div_capture;
    div_sel_t sel;
    logic     store;
    logic     bprep1;
    logic     bprep2;
    logic     bstore;
    logic     bcheck;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic calib;
    logic just_pressed;
    logic just_released;
    logic result_valid;
    logic sum_last;
    logic last_corner;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

### src/tfpc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Unsigned operands; sizes come from tfpc_pkg.
`timescale 1ns / 1ps

module tfpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tfpc_pkg::DIV_NW-1:0] num,
  input  logic [tfpc_pkg::DIV_DW-1:0] den,
  output logic                        busy,
  output logic [tfpc_pkg::DIV_NW-1:0] quo
);

  localparam int NW = tfpc_pkg::DIV_NW;
  localparam int DW = tfpc_pkg::DIV_DW;
  localparam int CW = tfpc_pkg::DIV_CW;

  logic [DW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   shift_nxt;
  logic          fits_nxt;

  assign shift_nxt = {rem_r, quo_r[NW-1]};
  assign fits_nxt  = shift_nxt >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
    end else if (busy_r) begin
      if (fits_nxt) begin
        rem_r <= DW'(shift_nxt - {1'b0, den_r});
      end else begin
        rem_r <= shift_nxt[DW-1:0];
      end
      quo_r <= {quo_r[NW-2:0], fits_nxt};
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

### src/tfpc_dpath.sv
// Datapath of the calibrator: configuration, sample window, corner store,
// bounds, coefficient math and the output register. Uses tfpc_pkg and tfpc_div.
`timescale 1ns / 1ps

module tfpc_dpath #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [12:0]                      cfg_data,
  input  logic [tfpc_pkg::RAW_BITS-1:0]    in_raw_x,
  input  logic [tfpc_pkg::RAW_BITS-1:0]    in_raw_y,
  input  logic                             in_pressed,
  input  tfpc_pkg::cmd_t                   cmd,
  output tfpc_pkg::stat_t                  stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [1:0]                       out_point_number,
  output logic [tfpc_pkg::RAW_BITS-1:0]    out_avg_x,
  output logic [tfpc_pkg::RAW_BITS-1:0]    out_avg_y,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_min_x_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_max_x_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_min_y_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_max_y_bound,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_gain_x,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_offset_x,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_gain_y,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_offset_y
);

  localparam int RB = tfpc_pkg::RAW_BITS;
  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = RB + FW;
  localparam int NW = tfpc_pkg::DIV_NW;
  localparam int DW = tfpc_pkg::DIV_DW;
  localparam int BW = tfpc_pkg::BND_W;
  localparam int CW = tfpc_pkg::COEF_W;

  localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [NW-1:0] COEF_POS_LIM = NW'(COEF_MAX);
  localparam logic [NW-1:0] COEF_NEG_LIM = COEF_POS_LIM + NW'(1);

  function automatic logic signed [BW-1:0] sat_bnd(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd4194303;
    lo = -32'sd4194304;
    if (v > hi) begin
      return BW'(hi);
    end else if (v < lo) begin
      return BW'(lo);
    end
    return BW'(v);
  endfunction

  logic [12:0] scr_w_r;
  logic [12:0] scr_h_r;
  logic [7:0]  xoff_r;
  logic [11:0] fs_r;

  logic [RB-1:0] in_x_r;
  logic [RB-1:0] in_y_r;
  logic          in_p_r;

  logic          was_touched_r;
  logic [FW-1:0] fill_r;
  logic [2:0]    phase_r;
  logic          rv_r;

  logic [2*RB-1:0] win_r [WINDOW_DEPTH];
  logic [IW-1:0]   idx_r;
  logic [SW-1:0]   sum_x_r;
  logic [SW-1:0]   sum_y_r;
  logic [RB-1:0]   ax_r;
  logic [RB-1:0]   ay_r;
  logic [RB-1:0]   cx_r [4];
  logic [RB-1:0]   cy_r [4];

  logic signed [21:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic signed [13:0] span_x_r, span_y_r;
  logic signed [30:0] prod_x_r, prod_y_r;
  logic signed [30:0] t_x_r, t_y_r;
  logic               zspan_r;
  logic signed [BW-1:0] bnd_r [4];
  logic               neg_r;

  logic [2:0]    res_status_r;
  logic [1:0]    res_pnum_r;
  logic [RB-1:0] res_ax_r;
  logic [RB-1:0] res_ay_r;
  logic signed [CW-1:0] res_coef_r [4];

  logic                 out_valid_r;
  logic                 div_busy;
  logic [NW-1:0]        div_quo;
  logic signed [40:0]   dn_nxt;
  logic signed [24:0]   dd_nxt;
  logic [NW-1:0]        n_abs_nxt;
  logic [DW-1:0]        d_abs_nxt;
  logic [NW-1:0]        div_num_nxt;
  logic signed [CW-1:0] span_bx_nxt, span_by_nxt;
  logic signed [30:0]   t_val_nxt;
  logic signed [CW-1:0] coef_sat_nxt;
  logic signed [23:0]   lim_nxt;
  logic                 ok_nxt;
  logic                 show_bnd_nxt;
  logic [2*RB-1:0]      sample_nxt;
  logic                 jp_nxt, jr_nxt, calib_nxt;

  assign jp_nxt     = in_p_r & ~was_touched_r;
  assign jr_nxt     = ~in_p_r & was_touched_r;
  assign calib_nxt  = ~phase_r[2];
  assign sample_nxt = {in_y_r, in_x_r};

  assign span_bx_nxt = CW'(bnd_r[1]) - CW'(bnd_r[0]);
  assign span_by_nxt = CW'(bnd_r[3]) - CW'(bnd_r[2]);

  always_comb begin
    dn_nxt = '0;
    dd_nxt = '0;
    unique case (cmd.sel)
      tfpc_pkg::DS_AVGX: begin
        dn_nxt = 41'(sum_x_r);
        dd_nxt = 25'(fill_r);
      end
      tfpc_pkg::DS_AVGY: begin
        dn_nxt = 41'(sum_y_r);
        dd_nxt = 25'(fill_r);
      end
      tfpc_pkg::DS_TX: begin
        dn_nxt = 41'(prod_x_r);
        dd_nxt = 25'(span_x_r);
      end
      tfpc_pkg::DS_TY: begin
        dn_nxt = 41'(prod_y_r);
        dd_nxt = 25'(span_y_r);
      end
      tfpc_pkg::DS_GX: begin
        dn_nxt = 41'({fs_r, 24'd0});
        dd_nxt = 25'(span_bx_nxt);
      end
      tfpc_pkg::DS_OX: begin
        dn_nxt = 41'($signed({bnd_r[0], 16'd0}));
        dd_nxt = -25'(span_bx_nxt);
      end
      tfpc_pkg::DS_GY: begin
        dn_nxt = 41'({fs_r, 24'd0});
        dd_nxt = 25'(span_by_nxt);
      end
      tfpc_pkg::DS_OY: begin
        dn_nxt = 41'($signed({bnd_r[2], 16'd0}));
        dd_nxt = -25'(span_by_nxt);
      end
      default: begin
        dn_nxt = '0;
        dd_nxt = '0;
      end
    endcase
  end

  // Rounding to nearest with ties away from zero works on magnitudes.
  assign n_abs_nxt   = dn_nxt[40] ? NW'(-dn_nxt) : dn_nxt[NW-1:0];
  assign d_abs_nxt   = dd_nxt[24] ? DW'(-dd_nxt) : dd_nxt[DW-1:0];
  assign div_num_nxt = n_abs_nxt + NW'(d_abs_nxt >> 1);

  tfpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num_nxt),
    .den   (d_abs_nxt),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign t_val_nxt = neg_r ? -31'(div_quo[29:0]) : 31'(div_quo[29:0]);

  always_comb begin
    if (!neg_r && div_quo > COEF_POS_LIM) begin
      coef_sat_nxt = COEF_MAX;
    end else if (neg_r && div_quo > COEF_NEG_LIM) begin
      coef_sat_nxt = COEF_MIN;
    end else if (neg_r) begin
      coef_sat_nxt = -CW'(div_quo[CW-1:0]);
    end else begin
      coef_sat_nxt = div_quo[CW-1:0];
    end
  end

  assign lim_nxt = $signed({4'd0, fs_r, 8'd0});
  assign ok_nxt  = !zspan_r && !bnd_r[0][BW-1] && !bnd_r[2][BW-1] &&
                   !(24'(bnd_r[1]) > lim_nxt) && !(24'(bnd_r[3]) > lim_nxt) &&
                   !(bnd_r[0] > bnd_r[1]) && !(bnd_r[2] > bnd_r[3]);

  assign show_bnd_nxt = (res_status_r == tfpc_pkg::ST_CAL_OK) ||
                        (res_status_r == tfpc_pkg::ST_CAL_ERR) ||
                        (res_status_r == tfpc_pkg::ST_COEF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= tfpc_pkg::SCREEN_W_RST;
      scr_h_r <= tfpc_pkg::SCREEN_H_RST;
      xoff_r  <= tfpc_pkg::XOFF_RST;
      fs_r    <= tfpc_pkg::FULL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tfpc_pkg::CFG_SCREEN_W: scr_w_r <= cfg_data;
        tfpc_pkg::CFG_SCREEN_H: scr_h_r <= cfg_data;
        tfpc_pkg::CFG_XOFF:     xoff_r  <= cfg_data[7:0];
        tfpc_pkg::CFG_FULL:     fs_r    <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_touched_r <= 1'b0;
      fill_r        <= '0;
      phase_r       <= '0;
      rv_r          <= 1'b0;
    end else begin
      if (cmd.edge_step) begin
        was_touched_r <= in_p_r;
        if (calib_nxt && fill_r < FW'(WINDOW_DEPTH)) begin
          fill_r <= fill_r + FW'(1);
        end
        if (!calib_nxt && jp_nxt) begin
          rv_r <= 1'b0;
        end
      end
      if (cmd.store) begin
        fill_r  <= '0;
        phase_r <= phase_r + 3'd1;
      end
      if (cmd.bcheck) begin
        rv_r <= ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_x_r <= in_raw_x;
      in_y_r <= in_raw_y;
      in_p_r <= in_pressed;
    end
    if (cmd.edge_step) begin
      if (calib_nxt) begin
        if (fill_r < FW'(WINDOW_DEPTH)) begin
          win_r[fill_r[IW-1:0]] <= sample_nxt;
        end else begin
          for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            win_r[i] <= win_r[i+1];
          end
          win_r[WINDOW_DEPTH-1] <= sample_nxt;
        end
      end
      idx_r        <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      res_pnum_r   <= '0;
      res_ax_r     <= '0;
      res_ay_r     <= '0;
      for (int i = 0; i < 4; i++) begin
        res_coef_r[i] <= '0;
      end
      if (!calib_nxt && jp_nxt) begin
        res_status_r <= rv_r ? tfpc_pkg::ST_COEF : tfpc_pkg::ST_QUIT;
      end else begin
        res_status_r <= tfpc_pkg::ST_NONE;
      end
    end
    if (cmd.sum_step) begin
      sum_x_r <= sum_x_r + SW'(win_r[idx_r][RB-1:0]);
      sum_y_r <= sum_y_r + SW'(win_r[idx_r][2*RB-1:RB]);
      idx_r   <= idx_r + IW'(1);
    end
    if (cmd.div_start) begin
      neg_r <= dn_nxt[40] ^ dd_nxt[24];
    end
    if (cmd.div_capture) begin
      unique case (cmd.sel)
        tfpc_pkg::DS_AVGX: ax_r <= div_quo[RB-1:0];
        tfpc_pkg::DS_AVGY: ay_r <= div_quo[RB-1:0];
        tfpc_pkg::DS_TX:   t_x_r <= (span_x_r == '0) ? '0 : t_val_nxt;
        tfpc_pkg::DS_TY:   t_y_r <= (span_y_r == '0) ? '0 : t_val_nxt;
        tfpc_pkg::DS_GX:   res_coef_r[0] <= (span_bx_nxt == '0) ? COEF_MAX : coef_sat_nxt;
        tfpc_pkg::DS_OX: begin
          if (span_bx_nxt == '0) begin
            res_coef_r[1] <= (bnd_r[0] == '0) ? '0 : COEF_MAX;
          end else begin
            res_coef_r[1] <= coef_sat_nxt;
          end
        end
        tfpc_pkg::DS_GY:   res_coef_r[2] <= (span_by_nxt == '0) ? COEF_MAX : coef_sat_nxt;
        tfpc_pkg::DS_OY: begin
          if (span_by_nxt == '0) begin
            res_coef_r[3] <= (bnd_r[2] == '0) ? '0 : COEF_MAX;
          end else begin
            res_coef_r[3] <= coef_sat_nxt;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.store) begin
      cx_r[phase_r[1:0]] <= ax_r;
      cy_r[phase_r[1:0]] <= ay_r;
      res_status_r       <= tfpc_pkg::ST_POINT;
      res_pnum_r         <= phase_r[1:0];
      res_ax_r           <= ax_r;
      res_ay_r           <= ay_r;
    end
    if (cmd.bprep1) begin
      lo_x_r   <= $signed(22'({(RB+1)'(cx_r[0]) + (RB+1)'(cx_r[3]), 7'd0}));
      hi_x_r   <= $signed(22'({(RB+1)'(cx_r[1]) + (RB+1)'(cx_r[2]), 7'd0}));
      lo_y_r   <= $signed(22'({(RB+1)'(cy_r[0]) + (RB+1)'(cy_r[1]), 7'd0}));
      hi_y_r   <= $signed(22'({(RB+1)'(cy_r[2]) + (RB+1)'(cy_r[3]), 7'd0}));
      span_x_r <= $signed(14'(scr_w_r)) - $signed(14'({xoff_r, 1'b0}));
      span_y_r <= $signed(14'(scr_h_r)) - $signed(14'({xoff_r, 1'b0}));
    end
    if (cmd.bprep2) begin
      prod_x_r <= (hi_x_r - lo_x_r) * $signed({1'b0, xoff_r});
      prod_y_r <= (hi_y_r - lo_y_r) * $signed({1'b0, xoff_r});
    end
    if (cmd.bstore) begin
      bnd_r[0] <= sat_bnd(32'(lo_x_r) - 32'(t_x_r));
      bnd_r[1] <= sat_bnd(32'(hi_x_r) + 32'(t_x_r));
      bnd_r[2] <= sat_bnd(32'(lo_y_r) - 32'(t_y_r));
      bnd_r[3] <= sat_bnd(32'(hi_y_r) + 32'(t_y_r));
      zspan_r  <= (span_x_r == '0) || (span_y_r == '0);
    end
    if (cmd.bcheck) begin
      res_status_r <= ok_nxt ? tfpc_pkg::ST_CAL_OK : tfpc_pkg::ST_CAL_ERR;
    end
    if (cmd.load_out) begin
      out_status       <= res_status_r;
      out_point_number <= res_pnum_r;
      out_avg_x        <= res_ax_r;
      out_avg_y        <= res_ay_r;
      out_min_x_bound  <= show_bnd_nxt ? bnd_r[0] : '0;
      out_max_x_bound  <= show_bnd_nxt ? bnd_r[1] : '0;
      out_min_y_bound  <= show_bnd_nxt ? bnd_r[2] : '0;
      out_max_y_bound  <= show_bnd_nxt ? bnd_r[3] : '0;
      out_gain_x       <= res_coef_r[0];
      out_offset_x     <= res_coef_r[1];
      out_gain_y       <= res_coef_r[2];
      out_offset_y     <= res_coef_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.calib         = calib_nxt;
  assign stat.just_pressed  = jp_nxt;
  assign stat.just_released = jr_nxt;
  assign stat.result_valid  = rv_r;
  assign stat.sum_last      = FW'(idx_r) == (fill_r - FW'(1));
  assign stat.last_corner   = phase_r == tfpc_pkg::LAST_CORNER;
  assign stat.div_busy      = div_busy;
  assign stat.out_free      = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(WINDOW_DEPTH))
    else $error("window fill count past depth");
  a_rv_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> phase_r == 3'd4)
    else $error("valid calibration before all corners");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

### src/tfpc_ctrl.sv
// Controller state machine of the calibrator.
// Sequences the datapath through tfpc_pkg command and status structs.
`timescale 1ns / 1ps

module tfpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tfpc_pkg::stat_t stat,
  output tfpc_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_EDGE   = 11'b00000000010,
    S_SUM    = 11'b00000000100,
    S_DSTART = 11'b00000001000,
    S_DWAIT  = 11'b00000010000,
    S_STORE  = 11'b00000100000,
    S_BPREP1 = 11'b00001000000,
    S_BPREP2 = 11'b00010000000,
    S_BSTORE = 11'b00100000000,
    S_BCHECK = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  tfpc_pkg::div_sel_t  sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_step = 1'b1;
        if (stat.calib && stat.just_released) begin
          state_nxt = S_SUM;
        end else if (!stat.calib && stat.just_pressed && stat.result_valid) begin
          sel_nxt   = tfpc_pkg::DS_GX;
          state_nxt = S_DSTART;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_last) begin
          sel_nxt   = tfpc_pkg::DS_AVGX;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          cmd.div_capture = 1'b1;
          unique case (sel_r)
            tfpc_pkg::DS_AVGX: begin
              sel_nxt   = tfpc_pkg::DS_AVGY;
              state_nxt = S_DSTART;
            end
            tfpc_pkg::DS_AVGY: state_nxt = S_STORE;
            tfpc_pkg::DS_TX: begin
              sel_nxt   = tfpc_pkg::DS_TY;
              state_nxt = S_DSTART;
            end
            tfpc_pkg::DS_TY: state_nxt = S_BSTORE;
            tfpc_pkg::DS_GX: begin
              sel_nxt   = tfpc_pkg::DS_OX;
              state_nxt = S_DSTART;
            end
            tfpc_pkg::DS_OX: begin
              sel_nxt   = tfpc_pkg::DS_GY;
              state_nxt = S_DSTART;
            end
            tfpc_pkg::DS_GY: begin
              sel_nxt   = tfpc_pkg::DS_OY;
              state_nxt = S_DSTART;
            end
            tfpc_pkg::DS_OY: state_nxt = S_FIN;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = stat.last_corner ? S_BPREP1 : S_FIN;
      end
      S_BPREP1: begin
        cmd.bprep1 = 1'b1;
        state_nxt  = S_BPREP2;
      end
      S_BPREP2: begin
        cmd.bprep2 = 1'b1;
        sel_nxt    = tfpc_pkg::DS_TX;
        state_nxt  = S_DSTART;
      end
      S_BSTORE: begin
        cmd.bstore = 1'b1;
        state_nxt  = S_BCHECK;
      end
      S_BCHECK: begin
        cmd.bcheck = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= tfpc_pkg::DS_AVGX;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

### src/touch_four_point_calibrator.sv
// Four-corner touchscreen calibrator. Each accepted touch report gives exactly one
// result transfer. A report that only updates edge state and the sample window passes
// through the latch, edge and result-load steps before the next report can be taken. A
// release during calibration adds a summing step per stored window sample, two serial
// divisions and a store step; the fourth corner adds the bound preparation, store and
// check steps and two more divisions for the bounds, and the press that releases the
// coefficients adds four divisions. Every division goes through one shared bit-serial
// divider, and the longest report is the fourth corner with a full window. A finished
// result waits in the output register while the next report is taken.
`timescale 1ns / 1ps

module touch_four_point_calibrator #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [12:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tfpc_pkg::RAW_BITS-1:0]    in_raw_x,
  input  logic [tfpc_pkg::RAW_BITS-1:0]    in_raw_y,
  input  logic                             in_pressed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [1:0]                       out_point_number,
  output logic [tfpc_pkg::RAW_BITS-1:0]    out_avg_x,
  output logic [tfpc_pkg::RAW_BITS-1:0]    out_avg_y,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_min_x_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_max_x_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_min_y_bound,
  output logic signed [tfpc_pkg::BND_W-1:0]  out_max_y_bound,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_gain_x,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_offset_x,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_gain_y,
  output logic signed [tfpc_pkg::COEF_W-1:0] out_offset_y
);

  tfpc_pkg::cmd_t  cmd;
  tfpc_pkg::stat_t stat;

  tfpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tfpc_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_raw_x         (in_raw_x),
    .in_raw_y         (in_raw_y),
    .in_pressed       (in_pressed),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_point_number (out_point_number),
    .out_avg_x        (out_avg_x),
    .out_avg_y        (out_avg_y),
    .out_min_x_bound  (out_min_x_bound),
    .out_max_x_bound  (out_max_x_bound),
    .out_min_y_bound  (out_min_y_bound),
    .out_max_y_bound  (out_max_y_bound),
    .out_gain_x       (out_gain_x),
    .out_offset_x     (out_offset_x),
    .out_gain_y       (out_gain_y),
    .out_offset_y     (out_offset_y)
  );

endmodule
